// ===== hdl/lrc_pkg.sv =====
// Package with the shared constants, types and codes of the line rasterizer.
package lrc_pkg;

  localparam int CoordWidth  = 12;
  localparam int SpanWidth   = 10;
  localparam int ColourWidth = 8;

  localparam int FrameWidth  = 400;
  localparam int FrameHeight = 400;
  localparam int MaxSpan     = 1000;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_STEP = 1'b1
  } mode_e;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic [SpanWidth-1:0]         span_t;
  typedef logic [ColourWidth-1:0]       colour_t;

  // Walk state of one line, passed between the setup, step and top modules.
  typedef struct packed {
    coord_t  cur_x;
    coord_t  cur_y;
    span_t   error_acc;
    span_t   steps_left;
    span_t   major_span;
    span_t   minor_span;
    logic    x_negative;
    logic    y_negative;
    logic    x_is_major;
    colour_t line_colour;
  } line_state_t;

  // Pixel produced by one step.
  typedef struct packed {
    coord_t  pixel_x;
    coord_t  pixel_y;
    colour_t pixel_colour;
    logic    in_frame;
    logic    last;
  } pixel_t;

endpackage

// ===== hdl/lrc_if.sv =====
// Valid/ready channel interfaces for the rasterizer input and output items.
interface lrc_in_if;
  logic                 valid;
  logic                 ready;
  logic                 mode;
  lrc_pkg::coord_t      start_x;
  lrc_pkg::coord_t      start_y;
  lrc_pkg::coord_t      end_x;
  lrc_pkg::coord_t      end_y;
  lrc_pkg::colour_t     colour;

  modport source (output valid, mode, start_x, start_y, end_x, end_y, colour, input ready);
  modport sink   (input valid, mode, start_x, start_y, end_x, end_y, colour, output ready);
endinterface

interface lrc_out_if;
  logic                 valid;
  logic                 ready;
  lrc_pkg::coord_t      pixel_x;
  lrc_pkg::coord_t      pixel_y;
  lrc_pkg::colour_t     pixel_colour;
  logic                 in_frame;
  logic                 last;

  modport source (output valid, pixel_x, pixel_y, pixel_colour, in_frame, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_colour, in_frame, last, output ready);
endinterface

// ===== hdl/line_rasterizer_clipped_unit.sv =====
// Top level of the clipped Bresenham line rasterizer.
//
// Usage: items arrive on in_i. An item with mode load latches two signed
// endpoints and a colour and arms a new line; it never gives a result.
// Lines whose x or y span is 1000 or more, and lines of zero length, are
// dropped and leave the block idle. Each item with mode step then yields
// one pixel on out_o, walking from the start point (which is not
// drawn) toward the end point. The pixel carries its colour, an in-frame
// flag for the 400 by 400 frame and a last flag on the end point. Step
// items while idle are consumed without a result; a load while a line is
// in progress abandons it.
// Flow: a step item accepted on in_i is held in the input register, and
// its pixel passes through the combinational step logic into the result
// register that drives out_o. Throughput is one item per cycle while the
// receiver takes results, set by the step logic between the registers.
// When the receiver stalls, the result register holds and the input
// register still takes one more item; in_i.ready falls only when both
// are full. Reset clears both registers and leaves the block idle.
module line_rasterizer_clipped_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  lrc_in_if.sink    in_i,
  lrc_out_if.source out_o
);

  // Input register.
  logic             in_valid_q;
  logic             mode_q;
  lrc_pkg::coord_t  start_x_q, start_y_q, end_x_q, end_y_q;
  lrc_pkg::colour_t colour_q;

  // Walk state.
  lrc_pkg::line_state_t state_q, state_d;
  logic                 busy_q, busy_d;

  // Result register.
  logic            out_valid_q, out_valid_d;
  lrc_pkg::pixel_t pixel_q, pixel_d;

  lrc_pkg::line_state_t setup_state, step_state;
  logic                 setup_drop;
  lrc_pkg::pixel_t      step_pixel;

  logic out_free;
  logic fire;
  logic is_load;

  // The result slot is free when empty or being drained this cycle.
  assign out_free   = !out_valid_q || out_o.ready;
  assign fire       = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || out_free;
  assign is_load    = (mode_q == lrc_pkg::MODE_LOAD);

  lrc_setup u_setup (
    .start_x_i (start_x_q),
    .start_y_i (start_y_q),
    .end_x_i   (end_x_q),
    .end_y_i   (end_y_q),
    .colour_i  (colour_q),
    .state_o   (setup_state),
    .drop_o    (setup_drop)
  );

  lrc_step u_step (
    .state_i (state_q),
    .state_o (step_state),
    .pixel_o (step_pixel)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      mode_q    <= in_i.mode;
      start_x_q <= in_i.start_x;
      start_y_q <= in_i.start_y;
      end_x_q   <= in_i.end_x;
      end_y_q   <= in_i.end_y;
      colour_q  <= in_i.colour;
    end
  end

  // A load replaces the walk state unless the line is dropped; a step while
  // busy advances it and fills the result register.
  always_comb begin
    state_d     = state_q;
    busy_d      = busy_q;
    pixel_d     = pixel_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (fire) begin
      if (is_load) begin
        busy_d = !setup_drop;
        if (!setup_drop) begin
          state_d = setup_state;
        end
      end else if (busy_q) begin
        state_d     = step_state;
        busy_d      = !step_pixel.last;
        pixel_d     = step_pixel;
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pixel_q <= pixel_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pixel_x      = pixel_q.pixel_x;
  assign out_o.pixel_y      = pixel_q.pixel_y;
  assign out_o.pixel_colour = pixel_q.pixel_colour;
  assign out_o.in_frame     = pixel_q.in_frame;
  assign out_o.last         = pixel_q.last;

endmodule

// ===== hdl/lrc_setup.sv =====
// Line setup: spans, directions, major axis and drop decision for a load item.
module lrc_setup (
  input  lrc_pkg::coord_t      start_x_i,
  input  lrc_pkg::coord_t      start_y_i,
  input  lrc_pkg::coord_t      end_x_i,
  input  lrc_pkg::coord_t      end_y_i,
  input  lrc_pkg::colour_t     colour_i,
  output lrc_pkg::line_state_t state_o,
  output logic                 drop_o
);

  localparam int DW = lrc_pkg::CoordWidth + 1;

  logic [DW-1:0]                   dx, dy;
  logic [DW-1:0]                   ax_w, ay_w;
  logic [lrc_pkg::CoordWidth-1:0]  ax, ay;
  logic                            x_major;
  lrc_pkg::span_t                  major;

  // The difference of two coordinates needs one extra bit.
  assign dx = {end_x_i[lrc_pkg::CoordWidth-1], end_x_i}
            - {start_x_i[lrc_pkg::CoordWidth-1], start_x_i};
  assign dy = {end_y_i[lrc_pkg::CoordWidth-1], end_y_i}
            - {start_y_i[lrc_pkg::CoordWidth-1], start_y_i};

  assign ax_w = dx[DW-1] ? (~dx + DW'(1)) : dx;
  assign ay_w = dy[DW-1] ? (~dy + DW'(1)) : dy;
  assign ax   = ax_w[lrc_pkg::CoordWidth-1:0];
  assign ay   = ay_w[lrc_pkg::CoordWidth-1:0];

  assign drop_o = (ax >= lrc_pkg::CoordWidth'(lrc_pkg::MaxSpan))
               || (ay >= lrc_pkg::CoordWidth'(lrc_pkg::MaxSpan))
               || ((ax == '0) && (ay == '0));

  // Ties make x the major axis.
  assign x_major = (ax >= ay);
  assign major   = x_major ? ax[lrc_pkg::SpanWidth-1:0] : ay[lrc_pkg::SpanWidth-1:0];

  always_comb begin
    state_o.cur_x       = start_x_i;
    state_o.cur_y       = start_y_i;
    state_o.x_negative  = dx[DW-1];
    state_o.y_negative  = dy[DW-1];
    state_o.x_is_major  = x_major;
    state_o.major_span  = major;
    state_o.minor_span  = x_major ? ay[lrc_pkg::SpanWidth-1:0] : ax[lrc_pkg::SpanWidth-1:0];
    state_o.error_acc   = major >> 1;
    state_o.steps_left  = major;
    state_o.line_colour = colour_i;
  end

endmodule

// ===== hdl/lrc_step.sv =====
// One Bresenham step: error update, coordinate moves, clip and last flags.
module lrc_step (
  input  lrc_pkg::line_state_t state_i,
  output lrc_pkg::line_state_t state_o,
  output lrc_pkg::pixel_t      pixel_o
);

  localparam int SW = lrc_pkg::SpanWidth + 1;

  logic [SW-1:0]   sum, sum_adj;
  logic            minor_move;
  logic            move_x, move_y;
  lrc_pkg::coord_t next_x, next_y;
  lrc_pkg::span_t  next_steps;

  assign sum        = {1'b0, state_i.error_acc} + {1'b0, state_i.minor_span};
  assign minor_move = (sum >= {1'b0, state_i.major_span});
  assign sum_adj    = minor_move ? (sum - {1'b0, state_i.major_span}) : sum;

  assign move_x = state_i.x_is_major || minor_move;
  assign move_y = !state_i.x_is_major || minor_move;

  always_comb begin
    next_x = state_i.cur_x;
    if (move_x) begin
      next_x = state_i.x_negative ? (state_i.cur_x - lrc_pkg::CoordWidth'(1))
                                  : (state_i.cur_x + lrc_pkg::CoordWidth'(1));
    end
    next_y = state_i.cur_y;
    if (move_y) begin
      next_y = state_i.y_negative ? (state_i.cur_y - lrc_pkg::CoordWidth'(1))
                                  : (state_i.cur_y + lrc_pkg::CoordWidth'(1));
    end
  end

  assign next_steps = state_i.steps_left - lrc_pkg::SpanWidth'(1);

  always_comb begin
    state_o            = state_i;
    state_o.cur_x      = next_x;
    state_o.cur_y      = next_y;
    state_o.error_acc  = sum_adj[lrc_pkg::SpanWidth-1:0];
    state_o.steps_left = next_steps;
  end

  // With the sign bit clear, the compare against the frame size is exact.
  always_comb begin
    pixel_o.pixel_x      = next_x;
    pixel_o.pixel_y      = next_y;
    pixel_o.pixel_colour = state_i.line_colour;
    pixel_o.in_frame     = !next_x[lrc_pkg::CoordWidth-1]
                        && !next_y[lrc_pkg::CoordWidth-1]
                        && (next_x < lrc_pkg::CoordWidth'(lrc_pkg::FrameWidth))
                        && (next_y < lrc_pkg::CoordWidth'(lrc_pkg::FrameHeight));
    pixel_o.last         = (next_steps == '0);
  end

endmodule

// ===== hdl/lrc_checker.sv =====
// Port-level checker for the line rasterizer and its bind to the top level.
module lrc_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             in_mode_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input lrc_pkg::coord_t  pixel_x_i,
  input lrc_pkg::coord_t  pixel_y_i,
  input lrc_pkg::colour_t pixel_colour_i,
  input logic             in_frame_i,
  input logic             last_i
);

  // A new result always comes from a step item taken on in_i, through the input and result registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i
                                 && (in_mode_i == lrc_pkg::MODE_STEP), 2))
    else $error("result appeared without a step item two cycles earlier");

  // The input side stalls only when the result register is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> (out_valid_i && !out_ready_i))
    else $error("input stalled while the result side could move");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result withdrawn before it was taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> ($stable(pixel_x_i) && $stable(pixel_y_i)
      && $stable(pixel_colour_i) && $stable(in_frame_i) && $stable(last_i)))
    else $error("result payload changed while stalled");

endmodule

bind line_rasterizer_clipped_unit lrc_checker u_lrc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_mode_i      (in_i.mode),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .pixel_x_i      (out_o.pixel_x),
  .pixel_y_i      (out_o.pixel_y),
  .pixel_colour_i (out_o.pixel_colour),
  .in_frame_i     (out_o.in_frame),
  .last_i         (out_o.last)
);
